// ----- src/yta_pkg.sv -----
// Shared constants, types and helper functions for the YUV text alpha blender.
package yta_pkg;

   // Fixed-point format of the colour-space coefficients
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_W         = COEF_FRAC_BITS + 2;
   localparam int PROD_W         = COEF_W + 8;
   localparam int SUM_W          = COEF_W + 9;

   // BT.601 coefficients, rounded half up
   localparam logic signed [COEF_W-1:0] K_RV =
      COEF_W'(((longint'(1402) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_GU =
      COEF_W'(((longint'(344136) << COEF_FRAC_BITS) + 500000) / 1000000);
   localparam logic signed [COEF_W-1:0] K_GV =
      COEF_W'(((longint'(714136) << COEF_FRAC_BITS) + 500000) / 1000000);
   localparam logic signed [COEF_W-1:0] K_BU =
      COEF_W'(((longint'(1772) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_YR =
      COEF_W'(((longint'(299) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_YG =
      COEF_W'(((longint'(587) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_YB =
      COEF_W'(((longint'(114) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_UR =
      COEF_W'(((longint'(169) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_UG =
      COEF_W'(((longint'(331) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_HALF =
      COEF_W'(((longint'(1) << COEF_FRAC_BITS) + 1) / 2);
   localparam logic signed [COEF_W-1:0] K_VG =
      COEF_W'(((longint'(419) << COEF_FRAC_BITS) + 500) / 1000);
   localparam logic signed [COEF_W-1:0] K_VB =
      COEF_W'(((longint'(81) << COEF_FRAC_BITS) + 500) / 1000);

   // Chroma offset of 128 in the sum format
   localparam logic signed [SUM_W-1:0] CHROMA_OFFSET =
      SUM_W'(longint'(128) << COEF_FRAC_BITS);

   // Blend weight scale (256 * 255)
   localparam logic [15:0] FULL_W         = 16'd65280;
   localparam logic [8:0]  OPACITY_FULL   = 9'd256;
   localparam int          NUM_W          = 24;
   localparam int          NUM_STAGES     = 6;

   // Register reset values
   localparam logic [7:0] TEXT_LUMA_RESET = 8'd255;
   localparam logic [7:0] TEXT_CB_RESET   = 8'd128;
   localparam logic [7:0] TEXT_CR_RESET   = 8'd128;
   localparam logic [8:0] OPACITY_RESET   = 9'd256;

   typedef enum logic [1:0] {
      CSR_TEXT_LUMA      = 2'd0,
      CSR_TEXT_CB        = 2'd1,
      CSR_TEXT_CR        = 2'd2,
      CSR_GLOBAL_OPACITY = 2'd3
   } csr_index_type;

   // Load enables of the two register stages inside a conversion unit
   typedef struct packed {
      logic lead;
      logic tail;
   } stage_en_type;

   // Pixel samples carried alongside the arithmetic, plus the bypass flag
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       pass;
   } pix_type;

   // Floor by 2^COEF_FRAC_BITS, then clamp to 0..255
   function automatic logic [7:0] floor_clamp(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] q;
      logic [7:0]              res;
      q = s >>> COEF_FRAC_BITS;
      priority if (s[SUM_W-1]) begin
         res = 8'd0;
      end else if (q[SUM_W-1:8] != '0) begin
         res = 8'd255;
      end else begin
         res = q[7:0];
      end
      return res;
   endfunction

endpackage

// ----- src/yta_yuv_to_rgb.sv -----
// Two-stage YUV to RGB converter: coefficient products, then sum, floor and clamp.
module yta_yuv_to_rgb
   import yta_pkg::*;
(
   input  logic             clock,
   input  stage_en_type     stage_en,
   input  logic [7:0]       luma,
   input  logic [7:0]       cb,
   input  logic [7:0]       cr,
   output logic [2:0][7:0]  rgb
);

   logic [7:0]               luma_ff;
   logic signed [PROD_W-1:0] rv_ff, gu_ff, gv_ff, bu_ff;
   logic signed [PROD_W-1:0] rv_in, gu_in, gv_in, bu_in;
   logic signed [7:0]        du, dv;
   logic signed [SUM_W-1:0]  ys, r_sum, g_sum, b_sum;
   logic [2:0][7:0]          rgb_ff, rgb_in;

   // Chroma minus 128 is the sample with its top bit flipped
   assign du = $signed({~cb[7], cb[6:0]});
   assign dv = $signed({~cr[7], cr[6:0]});

   always_comb begin
      rv_in = K_RV * dv;
      gu_in = K_GU * du;
      gv_in = K_GV * dv;
      bu_in = K_BU * du;
   end

   always_ff @(posedge clock) begin
      if (stage_en.lead) begin
         luma_ff <= luma;
         rv_ff   <= rv_in;
         gu_ff   <= gu_in;
         gv_ff   <= gv_in;
         bu_ff   <= bu_in;
      end
   end

   always_comb begin
      ys = {{(SUM_W - 8 - COEF_FRAC_BITS){1'b0}}, luma_ff, {COEF_FRAC_BITS{1'b0}}};
      r_sum = ys + {{(SUM_W - PROD_W){rv_ff[PROD_W-1]}}, rv_ff};
      g_sum = ys - {{(SUM_W - PROD_W){gu_ff[PROD_W-1]}}, gu_ff}
                 - {{(SUM_W - PROD_W){gv_ff[PROD_W-1]}}, gv_ff};
      b_sum = ys + {{(SUM_W - PROD_W){bu_ff[PROD_W-1]}}, bu_ff};
      rgb_in[0] = floor_clamp(r_sum);
      rgb_in[1] = floor_clamp(g_sum);
      rgb_in[2] = floor_clamp(b_sum);
   end

   always_ff @(posedge clock) begin
      if (stage_en.tail) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rgb = rgb_ff;

endmodule

// ----- src/yta_rgb_to_yuv.sv -----
// Two-stage RGB to YUV converter: coefficient products, then sum, floor and clamp.
module yta_rgb_to_yuv
   import yta_pkg::*;
(
   input  logic             clock,
   input  stage_en_type     stage_en,
   input  logic [2:0][7:0]  rgb,
   output logic [2:0][7:0]  yuv
);

   logic signed [8:0]       r_s, g_s, b_s;
   logic signed [SUM_W-1:0] yr_ff, yg_ff, yb_ff, ur_ff, ug_ff, ub_ff, vr_ff, vg_ff, vb_ff;
   logic signed [SUM_W-1:0] yr_in, yg_in, yb_in, ur_in, ug_in, ub_in, vr_in, vg_in, vb_in;
   logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;
   logic [2:0][7:0]         yuv_ff, yuv_in;

   assign r_s = $signed({1'b0, rgb[0]});
   assign g_s = $signed({1'b0, rgb[1]});
   assign b_s = $signed({1'b0, rgb[2]});

   always_comb begin
      yr_in = K_YR * r_s;
      yg_in = K_YG * g_s;
      yb_in = K_YB * b_s;
      ur_in = K_UR * r_s;
      ug_in = K_UG * g_s;
      ub_in = K_HALF * b_s;
      vr_in = K_HALF * r_s;
      vg_in = K_VG * g_s;
      vb_in = K_VB * b_s;
   end

   always_ff @(posedge clock) begin
      if (stage_en.lead) begin
         yr_ff <= yr_in;
         yg_ff <= yg_in;
         yb_ff <= yb_in;
         ur_ff <= ur_in;
         ug_ff <= ug_in;
         ub_ff <= ub_in;
         vr_ff <= vr_in;
         vg_ff <= vg_in;
         vb_ff <= vb_in;
      end
   end

   always_comb begin
      y_sum = yr_ff + yg_ff + yb_ff;
      u_sum = ub_ff - ur_ff - ug_ff + CHROMA_OFFSET;
      v_sum = vr_ff - vg_ff - vb_ff + CHROMA_OFFSET;
      yuv_in[0] = floor_clamp(y_sum);
      yuv_in[1] = floor_clamp(u_sum);
      yuv_in[2] = floor_clamp(v_sum);
   end

   always_ff @(posedge clock) begin
      if (stage_en.tail) begin
         yuv_ff <= yuv_in;
      end
   end

   assign yuv = yuv_ff;

endmodule

// ----- src/yuv_text_alpha_blend.sv -----
// Top level of the YUV text alpha blender: register file, blend pipeline and output stage.
//
// Usage
//   Input channel (req_*): one YUV pixel plus its glyph coverage per transfer.
//   Result channel (rsp_*): one blended YUV pixel per input transfer, in order.
//   Configuration (csr_*): text colour and global opacity, written one register
//   per cycle while no pixel is in flight.
// Timing
//   Six register stages: RGB products, RGB clamp, blend numerator, divide by
//   65280, YUV products, YUV clamp.
//   Throughput is one pixel per cycle while rsp_ready is high; every stage takes
//   a new item whenever it is empty or its successor advances.
//   The text colour is converted to RGB by its own two-stage unit running
//   continuously; a new colour passes its product and clamp registers before use.
// Reset
//   Reset empties the pipeline and loads the register reset values.
// Back-pressure
//   With rsp_ready low the output stage holds; earlier stages keep filling
//   until each holds an item, and only then does req_ready drop.
module yuv_text_alpha_blend
   import yta_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pix_luma,
   input  logic [7:0] req_pix_cb,
   input  logic [7:0] req_pix_cr,
   input  logic [7:0] req_coverage,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_luma,
   output logic [7:0] rsp_out_cb,
   output logic [7:0] rsp_out_cr,
   // configuration port
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_write_data
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0] text_luma_ff, text_cb_ff, text_cr_ff;
   logic [8:0] opacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_luma_ff <= TEXT_LUMA_RESET;
         text_cb_ff   <= TEXT_CB_RESET;
         text_cr_ff   <= TEXT_CR_RESET;
         opacity_ff   <= OPACITY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEXT_LUMA:      text_luma_ff <= csr_write_data[7:0];
            CSR_TEXT_CB:        text_cb_ff   <= csr_write_data[7:0];
            CSR_TEXT_CR:        text_cr_ff   <= csr_write_data[7:0];
            CSR_GLOBAL_OPACITY: opacity_ff   <= csr_write_data;
            default:            ;
         endcase
      end
   end

   // Text colour in RGB, refreshed every cycle from the registers
   logic [2:0][7:0] text_rgb;
   stage_en_type    text_en;

   assign text_en = '{lead: 1'b1, tail: 1'b1};

   yta_yuv_to_rgb u_text_rgb (
      .clock    (clock),
      .stage_en (text_en),
      .luma     (text_luma_ff),
      .cb       (text_cb_ff),
      .cr       (text_cr_ff),
      .rgb      (text_rgb)
   );

   // ---------------------------------------------------------------
   // Stage valid bits and load enables
   // ---------------------------------------------------------------
   logic [NUM_STAGES-1:0] stage_vld_ff, stage_vld_in;
   logic [NUM_STAGES-1:0] stage_en;

   // A stage loads when it is empty or its successor advances
   always_comb begin
      stage_en[NUM_STAGES-1] = !stage_vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !stage_vld_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      stage_vld_in[0] = stage_en[0] ? req_valid : stage_vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         stage_vld_in[k] = stage_en[k] ? stage_vld_ff[k-1] : stage_vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   assign req_ready = stage_en[0];

   // ---------------------------------------------------------------
   // Stages 1 and 2: pixel to RGB, blend weight, bypass data
   // ---------------------------------------------------------------
   logic [2:0][7:0] pix_rgb;
   stage_en_type    pix_en;
   pix_type         s1_pix_ff, s1_pix_in, s2_pix_ff;
   logic [15:0]     s1_w_ff, s1_w_in, s2_w_ff;
   logic [8:0]      opacity_sat;
   logic [16:0]     w_full;

   assign pix_en = '{lead: stage_en[0], tail: stage_en[1]};

   yta_yuv_to_rgb u_pix_rgb (
      .clock    (clock),
      .stage_en (pix_en),
      .luma     (req_pix_luma),
      .cb       (req_pix_cb),
      .cr       (req_pix_cr),
      .rgb      (pix_rgb)
   );

   // Saturate opacity above full, then form the weight out of 65280
   always_comb begin
      opacity_sat    = opacity_ff[8] ? OPACITY_FULL : opacity_ff;
      w_full         = opacity_sat * req_coverage;
      s1_w_in        = w_full[15:0];
      s1_pix_in.luma = req_pix_luma;
      s1_pix_in.cb   = req_pix_cb;
      s1_pix_in.cr   = req_pix_cr;
      s1_pix_in.pass = (req_coverage == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_pix_ff <= s1_pix_in;
         s1_w_ff   <= s1_w_in;
      end
      if (stage_en[1]) begin
         s2_pix_ff <= s1_pix_ff;
         s2_w_ff   <= s1_w_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: blend numerator  Cp*65280 + w*(Ct - Cp)
   // ---------------------------------------------------------------
   logic [2:0][NUM_W-1:0] s3_num_ff, s3_num_in;
   pix_type               s3_pix_ff;
   logic signed [8:0]     diff;
   logic signed [NUM_W+1:0] prod, num_ext;

   always_comb begin
      diff    = '0;
      prod    = '0;
      num_ext = '0;
      for (int c = 0; c < 3; c++) begin
         diff    = $signed({1'b0, text_rgb[c]}) - $signed({1'b0, pix_rgb[c]});
         prod    = $signed({1'b0, s2_w_ff}) * diff;
         num_ext = $signed({2'b00, pix_rgb[c], 16'd0})
                 - $signed({10'd0, pix_rgb[c], 8'd0}) + prod;
         s3_num_in[c] = num_ext[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_num_ff <= s3_num_in;
         s3_pix_ff <= s2_pix_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: divide by 65280 as a shift by 8 and a divide by 255
   // ---------------------------------------------------------------
   function automatic logic [7:0] div_full(input logic [NUM_W-1:0] num);
      logic [15:0] m;
      logic [24:0] t;
      logic [7:0]  q0;
      logic [16:0] r;
      m  = num[NUM_W-1:8];
      // Reciprocal estimate m*257/65536 is low by at most one
      t  = {1'b0, m, 8'd0} + {9'd0, m};
      q0 = t[23:16];
      r  = {1'b0, m} - {1'b0, q0, 8'd0} + {9'd0, q0};
      return (r >= 17'd255) ? q0 + 8'd1 : q0;
   endfunction

   logic [2:0][7:0] s4_rgb_ff, s4_rgb_in;
   pix_type         s4_pix_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s4_rgb_in[c] = div_full(s3_num_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_rgb_ff <= s4_rgb_in;
         s4_pix_ff <= s3_pix_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stages 5 and 6: back to YUV, then pick bypass or blended pixel
   // ---------------------------------------------------------------
   logic [2:0][7:0] blend_yuv;
   stage_en_type    yuv_en;
   pix_type         s5_pix_ff, s6_pix_ff;

   assign yuv_en = '{lead: stage_en[4], tail: stage_en[5]};

   yta_rgb_to_yuv u_blend_yuv (
      .clock    (clock),
      .stage_en (yuv_en),
      .rgb      (s4_rgb_ff),
      .yuv      (blend_yuv)
   );

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_pix_ff <= s4_pix_ff;
      end
      if (stage_en[5]) begin
         s6_pix_ff <= s5_pix_ff;
      end
   end

   // Zero coverage passes the original pixel through untouched
   assign rsp_valid    = stage_vld_ff[NUM_STAGES-1];
   assign rsp_out_luma = s6_pix_ff.pass ? s6_pix_ff.luma : blend_yuv[0];
   assign rsp_out_cb   = s6_pix_ff.pass ? s6_pix_ff.cb   : blend_yuv[1];
   assign rsp_out_cr   = s6_pix_ff.pass ? s6_pix_ff.cr   : blend_yuv[2];

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // Reset leaves the pipeline empty
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> (stage_vld_ff == '0))
      else $error("pipeline not empty after reset");

   // A full pipeline with a stalled receiver refuses new transfers
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      ((stage_vld_ff == '1) && !rsp_ready) |-> !req_ready)
      else $error("input accepted while pipeline full and stalled");

   // A held first stage keeps its weight
   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_vld_ff[0] && !stage_en[1] && !stage_en[0]) |=> $stable(s1_w_ff))
      else $error("stalled stage 1 weight changed");

endmodule
